### hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent property checks for simulation; empty bodies for synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication, disabled while reset is held
`define SFR_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication, disabled while reset is held
`define SFR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define SFR_ASSERT_NOW(label, clk, rst_n, ante, cons, msg)
`define SFR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif

`endif

### hw/rtl/sfr_pkg.sv
// ----------------------------------------------------------------------------
// sfr_pkg
// Shared types, constants and helpers of the stream find-and-replace block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package sfr_pkg;

  localparam int MAX_PATTERN     = 8;
  localparam int MAX_REPLACEMENT = 8;

  typedef logic [7:0]  byte_t;
  typedef logic [3:0]  cnt_t;
  typedef logic [63:0] word_t;
  typedef logic [3:0]  cfg_idx_t;

  // Configuration register indexes
  localparam cfg_idx_t CFG_PATTERN_BYTES      = 4'd0;
  localparam cfg_idx_t CFG_PATTERN_LENGTH     = 4'd1;
  localparam cfg_idx_t CFG_REPLACEMENT_BYTES  = 4'd2;
  localparam cfg_idx_t CFG_REPLACEMENT_LENGTH = 4'd3;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic take;       // transaction accepted on the input
    logic emit_pop;   // emit oldest pending byte and shift the window
    logic emit_repl;  // emit next replacement byte
    logic emit_mark;  // emit an empty end marker
    logic emit_last;  // flag the emitted result as last
    logic clr_cnt;    // drop the matched window
  } cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic prefix;     // window is a prefix of the active pattern
    logic full;       // window holds the whole pattern
    logic cnt_zero;   // window empty
    logic cnt_one;    // exactly one pending byte
    logic repl_none;  // replacement is empty
    logic repl_last;  // next replacement byte is the final one
    logic out_free;   // result register can take a result this cycle
    logic end_flag;   // current item closes the content
    logic emitted;    // current item has produced a result
  } sts_t;

  // Clamp pattern length into 1..MAX_PATTERN
  function automatic cnt_t clamp_plen(input cnt_t len);
    cnt_t res;
    res = len;
    if (len == 4'd0) res = 4'd1;
    if (len > 4'(MAX_PATTERN)) res = 4'(MAX_PATTERN);
    return res;
  endfunction

  // Clamp replacement length into 0..MAX_REPLACEMENT
  function automatic cnt_t clamp_rlen(input cnt_t len);
    cnt_t res;
    res = len;
    if (len > 4'(MAX_REPLACEMENT)) res = 4'(MAX_REPLACEMENT);
    return res;
  endfunction

endpackage
`default_nettype wire

### hw/rtl/sfr_ifs.sv
// ----------------------------------------------------------------------------
// sfr channel interfaces
// Valid/ready channels for content input, results and configuration writes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
interface sfr_in_if import sfr_pkg::*; ();
  logic  valid;
  logic  ready;
  byte_t data_byte;
  logic  byte_present;
  logic  end_of_content;
  modport source (output valid, data_byte, byte_present, end_of_content, input ready);
  modport sink   (input valid, data_byte, byte_present, end_of_content, output ready);
endinterface

interface sfr_out_if import sfr_pkg::*; ();
  logic  valid;
  logic  ready;
  byte_t out_byte;
  logic  out_valid;
  logic  out_last;
  modport source (output valid, out_byte, out_valid, out_last, input ready);
  modport sink   (input valid, out_byte, out_valid, out_last, output ready);
endinterface

interface sfr_cfg_if import sfr_pkg::*; ();
  logic     valid;
  logic     ready;
  cfg_idx_t index;
  word_t    data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

### hw/rtl/sfr_dp.sv
// ----------------------------------------------------------------------------
// sfr_dp
// Datapath: configuration registers, pending window, prefix compare and the
// result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module sfr_dp import sfr_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  // configuration writes
  input  wire logic     cfg_we,
  input  wire cfg_idx_t cfg_idx,
  input  wire word_t    cfg_data,
  // input item
  input  wire byte_t    in_data,
  input  wire logic     in_present,
  input  wire logic     in_end,
  // controller
  input  wire cmd_t     cmd,
  output sts_t          sts,
  // result register
  input  wire logic     res_ready,
  output logic          res_vld,
  output byte_t         res_byte,
  output logic          res_valid,
  output logic          res_last
);

  word_t cfg_pat_r, cfg_rep_r;
  cnt_t  cfg_plen_r, cfg_rlen_r;
  word_t act_pat_r, act_pat_nxt;
  cnt_t  act_len_r, act_len_nxt;
  byte_t win_r [MAX_PATTERN];
  byte_t win_nxt [MAX_PATTERN];
  cnt_t  cnt_r, cnt_nxt;
  logic [2:0] ri_r, ri_nxt;
  logic  end_r, end_nxt;
  logic  emitted_r, emitted_nxt;
  logic  ovld_r, ovld_nxt;
  byte_t obyte_r, obyte_nxt;
  logic  oval_r, oval_nxt;
  logic  olast_r, olast_nxt;
  cnt_t  rlen;
  logic  match;
  logic  emit_any;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_pat_r  <= '0;
      cfg_plen_r <= 4'd1;
      cfg_rep_r  <= '0;
      cfg_rlen_r <= '0;
    end else if (cfg_we) begin
      case (cfg_idx)
        CFG_PATTERN_BYTES:      cfg_pat_r  <= cfg_data;
        CFG_PATTERN_LENGTH:     cfg_plen_r <= cfg_data[3:0];
        CFG_REPLACEMENT_BYTES:  cfg_rep_r  <= cfg_data;
        CFG_REPLACEMENT_LENGTH: cfg_rlen_r <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  // Compare the window against the active pattern, one lane per entry
  always_comb begin
    match = (cnt_r <= act_len_r);
    for (int i = 0; i < MAX_PATTERN; i++) begin
      if (4'(i) < cnt_r && win_r[i] != act_pat_r[i*8 +: 8]) match = 1'b0;
    end
  end

  assign rlen     = clamp_rlen(cfg_rlen_r);
  assign emit_any = cmd.emit_pop | cmd.emit_repl | cmd.emit_mark;

  always_comb begin
    sts.prefix    = match;
    sts.full      = (cnt_r == act_len_r);
    sts.cnt_zero  = (cnt_r == 4'd0);
    sts.cnt_one   = (cnt_r == 4'd1);
    sts.repl_none = (rlen == 4'd0);
    sts.repl_last = ({1'b0, ri_r} == rlen - 4'd1);
    sts.out_free  = !ovld_r || res_ready;
    sts.end_flag  = end_r;
    sts.emitted   = emitted_r;
  end

  // Window, counters and result register next values
  always_comb begin
    act_pat_nxt = act_pat_r;
    act_len_nxt = act_len_r;
    win_nxt     = win_r;
    cnt_nxt     = cnt_r;
    ri_nxt      = ri_r;
    end_nxt     = end_r;
    emitted_nxt = emitted_r;
    ovld_nxt    = ovld_r;
    obyte_nxt   = obyte_r;
    oval_nxt    = oval_r;
    olast_nxt   = olast_r;

    // take a new item: latch the pattern on an empty window, push the byte
    if (cmd.take) begin
      if (cnt_r == 4'd0) begin
        act_pat_nxt = cfg_pat_r;
        act_len_nxt = clamp_plen(cfg_plen_r);
      end
      if (in_present) begin
        win_nxt[cnt_r[2:0]] = in_data;
        cnt_nxt = cnt_r + 4'd1;
      end
      end_nxt     = in_end;
      emitted_nxt = 1'b0;
      ri_nxt      = '0;
    end

    // drop the oldest byte and realign
    if (cmd.emit_pop) begin
      for (int i = 0; i < MAX_PATTERN - 1; i++) begin
        win_nxt[i] = win_r[i+1];
      end
      cnt_nxt = cnt_r - 4'd1;
    end

    if (cmd.clr_cnt) cnt_nxt = '0;
    if (cmd.emit_repl) ri_nxt = ri_r + 3'd1;

    // load or drain the result register
    if (emit_any) begin
      emitted_nxt = 1'b1;
      ovld_nxt    = 1'b1;
      olast_nxt   = cmd.emit_last;
      oval_nxt    = !cmd.emit_mark;
      if (cmd.emit_pop)       obyte_nxt = win_r[0];
      else if (cmd.emit_repl) obyte_nxt = cfg_rep_r[{ri_r, 3'b000} +: 8];
      else                    obyte_nxt = '0;
    end else if (res_ready) begin
      ovld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_pat_r <= '0;
      act_len_r <= 4'd1;
      cnt_r     <= '0;
      ri_r      <= '0;
      end_r     <= 1'b0;
      emitted_r <= 1'b0;
      ovld_r    <= 1'b0;
    end else begin
      act_pat_r <= act_pat_nxt;
      act_len_r <= act_len_nxt;
      cnt_r     <= cnt_nxt;
      ri_r      <= ri_nxt;
      end_r     <= end_nxt;
      emitted_r <= emitted_nxt;
      ovld_r    <= ovld_nxt;
    end
  end

  // Payload registers hold without reset
  always_ff @(posedge clk) begin
    win_r   <= win_nxt;
    obyte_r <= obyte_nxt;
    oval_r  <= oval_nxt;
    olast_r <= olast_nxt;
  end

  assign res_vld   = ovld_r;
  assign res_byte  = obyte_r;
  assign res_valid = oval_r;
  assign res_last  = olast_r;

  `SFR_ASSERT_NOW(a_cnt_bound, clk, rst_n, 1'b1, cnt_r <= 4'(MAX_PATTERN), "window overfilled")
  `SFR_ASSERT_NEXT(a_emit_shown, clk, rst_n, emit_any, ovld_r, "emitted result not registered")
  `SFR_ASSERT_NEXT(a_latch_len, clk, rst_n, cmd.take && cnt_r == 4'd0,
                   act_len_r == clamp_plen($past(cfg_plen_r)), "pattern not latched")

endmodule
`default_nettype wire

### hw/rtl/sfr_ctrl.sv
// ----------------------------------------------------------------------------
// sfr_ctrl
// Controller: sequences compare, realignment, replacement and flush per item.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module sfr_ctrl import sfr_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  input  wire logic in_present,
  input  wire logic in_end,
  output logic      in_ready,
  input  wire sts_t sts,
  output cmd_t      cmd
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_CHECK = 2'd1;
  localparam logic [1:0] S_REPL  = 2'd2;
  localparam logic [1:0] S_FLUSH = 2'd3;

  logic [1:0] state_r, state_nxt;
  logic       in_fire;
  logic [1:0] done_state;

  assign in_ready   = (state_r == S_IDLE);
  assign in_fire    = in_valid && in_ready;
  assign done_state = sts.end_flag ? S_FLUSH : S_IDLE;

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          cmd.take = 1'b1;
          if (in_present)  state_nxt = S_CHECK;
          else if (in_end) state_nxt = S_FLUSH;
        end
      end
      S_CHECK: begin
        if (!sts.prefix) begin
          // realign: emit the oldest pending byte
          if (sts.out_free) begin
            cmd.emit_pop  = 1'b1;
            cmd.emit_last = sts.end_flag && sts.cnt_one;
          end
        end else if (sts.full) begin
          cmd.clr_cnt = 1'b1;
          state_nxt   = sts.repl_none ? done_state : S_REPL;
        end else begin
          state_nxt = done_state;
        end
      end
      S_REPL: begin
        if (sts.out_free) begin
          cmd.emit_repl = 1'b1;
          cmd.emit_last = sts.end_flag && sts.repl_last;
          if (sts.repl_last) state_nxt = done_state;
        end
      end
      S_FLUSH: begin
        if (!sts.cnt_zero) begin
          if (sts.out_free) begin
            cmd.emit_pop  = 1'b1;
            cmd.emit_last = sts.cnt_one;
          end
        end else if (!sts.emitted) begin
          // nothing came out of this content tail: send an empty marker
          if (sts.out_free) begin
            cmd.emit_mark = 1'b1;
            cmd.emit_last = 1'b1;
            state_nxt     = S_IDLE;
          end
        end else begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  `SFR_ASSERT_NOW(a_one_emit, clk, rst_n, 1'b1,
                  $onehot0({cmd.emit_pop, cmd.emit_repl, cmd.emit_mark}), "multiple emits")
  `SFR_ASSERT_NOW(a_emit_room, clk, rst_n,
                  cmd.emit_pop || cmd.emit_repl || cmd.emit_mark, sts.out_free,
                  "emit into occupied result register")
  `SFR_ASSERT_NOW(a_mark_empty, clk, rst_n, cmd.emit_mark, sts.cnt_zero && !sts.emitted,
                  "end marker with pending output")
  `SFR_ASSERT_NEXT(a_byte_check, clk, rst_n, in_fire && in_present, state_r == S_CHECK,
                   "byte not compared")

endmodule
`default_nettype wire

### hw/rtl/stream_find_and_replace.sv
// ----------------------------------------------------------------------------
// stream_find_and_replace
// Replaces each leftmost non-overlapping pattern occurrence in a byte stream.
// ----------------------------------------------------------------------------
// Sequencing: a byte is accepted in the idle state and compared in the check
//   state, which pops one byte per emit on realignment; a match sends one
//   replacement byte per emit, and an end flushes the rest in the flush state.
//   Results are registered and appear in the cycle after the controller emits
//   them. Input is taken only when idle, so a new byte waits for the last one.
// Reset: synchronous rst_n empties the window and result register, restores
//   configuration defaults (pattern length one, empty replacement).
`timescale 1ns / 1ps
`default_nettype none
module stream_find_and_replace import sfr_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  sfr_in_if.sink    in_chan,
  sfr_out_if.source out_chan,
  sfr_cfg_if.sink   cfg_chan
);

  cmd_t cmd;
  sts_t sts;

  // Configuration writes are always taken
  assign cfg_chan.ready = 1'b1;

  sfr_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_chan.valid),
    .in_present (in_chan.byte_present),
    .in_end     (in_chan.end_of_content),
    .in_ready   (in_chan.ready),
    .sts        (sts),
    .cmd        (cmd)
  );

  sfr_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_chan.valid),
    .cfg_idx    (cfg_chan.index),
    .cfg_data   (cfg_chan.data),
    .in_data    (in_chan.data_byte),
    .in_present (in_chan.byte_present),
    .in_end     (in_chan.end_of_content),
    .cmd        (cmd),
    .sts        (sts),
    .res_ready  (out_chan.ready),
    .res_vld    (out_chan.valid),
    .res_byte   (out_chan.out_byte),
    .res_valid  (out_chan.out_valid),
    .res_last   (out_chan.out_last)
  );

endmodule
`default_nettype wire

### sim/sfr_result_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfr_result_checker
// Watches the input, result and configuration channels of the stream
// find-and-replace block. Keeps its own copy of the match window and the
// register file, works out the bytes each accepted input transaction must
// produce, and compares every accepted result with the oldest one still due.
// ----------------------------------------------------------------------------
module sfr_result_checker import sfr_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  sfr_in_if    in_mon,
  sfr_out_if   out_mon,
  sfr_cfg_if   cfg_mon,
  output int   fail_count,
  output int   awaited
);

  typedef struct packed {
    byte_t data;
    logic  has_byte;
    logic  last;
  } result_t;

  // Results still due from the block, oldest first
  result_t due_results[$];

  // Register file as written over the configuration port
  word_t reg_pattern;
  cnt_t  reg_plen;
  word_t reg_replacement;
  cnt_t  reg_rlen;

  // Match window and the pattern it is judged against
  byte_t window [MAX_PATTERN];
  int    win_fill;
  word_t live_pattern;
  int    live_len;

  int mismatches;

  assign fail_count = mismatches;

  // Print one line and count it
  task automatic report_mismatch(input string msg);
    $display("[%0t] sfr_result_checker: %s", $time, msg);
    mismatches++;
  endtask

  task automatic compare_field(input string name, input int unsigned got,
                               input int unsigned wanted);
    if (got != wanted)
      report_mismatch($sformatf("%s is %0h, want %0h", name, got, wanted));
  endtask

  // Take a fresh copy of the pattern; length zero acts as one, large values saturate
  function void latch_pattern();
    live_pattern = reg_pattern;
    if (reg_plen == 4'd0) live_len = 1;
    else if (reg_plen > 4'(MAX_PATTERN)) live_len = MAX_PATTERN;
    else live_len = int'(reg_plen);
  endfunction

  function void queue_result(input byte_t b, input logic has_byte);
    result_t r;
    r.data     = b;
    r.has_byte = has_byte;
    r.last     = 1'b0;
    due_results.push_back(r);
  endfunction

  // Emit the oldest pending byte and shift the window down
  function void pop_oldest();
    queue_result(window[0], 1'b1);
    for (int i = 0; i < MAX_PATTERN - 1; i++) window[i] = window[i + 1];
    win_fill--;
  endfunction

  function bit window_is_prefix();
    if (win_fill > live_len) return 1'b0;
    for (int i = 0; i < win_fill; i++)
      if (window[i] != live_pattern[i*8 +: 8]) return 1'b0;
    return 1'b1;
  endfunction

  // Work out the results of one accepted input transaction
  function void advance_window(input byte_t b, input logic present, input logic eoc);
    int      first;
    int      rl;
    result_t tail;
    first = due_results.size();
    // a new pattern only applies once nothing is pending
    if (win_fill == 0) latch_pattern();
    if (present) begin
      if (win_fill >= MAX_PATTERN) pop_oldest();
      window[win_fill] = b;
      win_fill++;
      // realign until the window is a prefix again, replace on a full match
      while (win_fill > 0) begin
        if (window_is_prefix()) begin
          if (win_fill == live_len) begin
            rl = (reg_rlen > 4'(MAX_REPLACEMENT)) ? MAX_REPLACEMENT : int'(reg_rlen);
            for (int i = 0; i < rl; i++) queue_result(reg_replacement[i*8 +: 8], 1'b1);
            win_fill = 0;
          end
          break;
        end
        pop_oldest();
      end
    end
    if (eoc) begin
      // flush, and mark the final result; an empty marker if nothing came out
      while (win_fill > 0) pop_oldest();
      if (due_results.size() == first) queue_result(8'h00, 1'b0);
      tail = due_results.pop_back();
      tail.last = 1'b1;
      due_results.push_back(tail);
    end
  endfunction

  function void write_register(input cfg_idx_t idx, input word_t val);
    case (idx)
      CFG_PATTERN_BYTES:      reg_pattern     = val;
      CFG_PATTERN_LENGTH:     reg_plen        = val[3:0];
      CFG_REPLACEMENT_BYTES:  reg_replacement = val;
      CFG_REPLACEMENT_LENGTH: reg_rlen        = val[3:0];
      default: ;
    endcase
  endfunction

  task automatic check_result();
    result_t want;
    if (due_results.size() == 0) begin
      report_mismatch($sformatf("result with nothing due: byte %02h valid %0b last %0b",
                                out_mon.out_byte, out_mon.out_valid, out_mon.out_last));
    end else begin
      want = due_results.pop_front();
      compare_field("out_byte", out_mon.out_byte, want.data);
      compare_field("out_valid", out_mon.out_valid, want.has_byte);
      compare_field("out_last", out_mon.out_last, want.last);
    end
  endtask

  // Sample every channel at the clock edge
  always @(posedge clk) begin
    if (!rst_n) begin
      reg_pattern     = '0;
      reg_plen        = 4'd1;
      reg_replacement = '0;
      reg_rlen        = 4'd0;
      win_fill        = 0;
      latch_pattern();
      due_results.delete();
    end else begin
      if (cfg_mon.valid && cfg_mon.ready) write_register(cfg_mon.index, cfg_mon.data);
      if (out_mon.valid && out_mon.ready) check_result();
      if (in_mon.valid && in_mon.ready)
        advance_window(in_mon.data_byte, in_mon.byte_present, in_mon.end_of_content);
    end
    awaited <= due_results.size();
  end

endmodule

### sim/stream_find_and_replace_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stream_find_and_replace_tb
// Drives byte content through the find-and-replace block: a short directed
// run over the corner cases, then phases of random content built largely
// from the current pattern, each under a new register setting and one of three idle mixes.
// A separate checker predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module stream_find_and_replace_tb;
  import sfr_pkg::*;

  localparam int          CYCLE_LIMIT        = 400000;
  localparam int          SETTLE_CYCLES      = 24;
  localparam int unsigned LONG_HOLD          = 400;
  localparam int          NUM_PHASES         = 12;
  localparam int          ITEMS_PER_PHASE    = 34;
  localparam int          HOLD_PHASE         = 9;
  localparam cfg_idx_t    FIRST_UNUSED_INDEX = CFG_REPLACEMENT_LENGTH + 4'd1;
  localparam byte_t       CHAR_A             = 8'h41;
  localparam byte_t       CHAR_B             = 8'h42;
  localparam byte_t       CHAR_C             = 8'h43;

  logic        clk;
  logic        rst_n;
  int          fail_count;
  int          awaited;
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  bit          hold_token;
  int unsigned cycle_count;
  word_t       cur_pattern;
  int          cur_plen;
  int          phase_items;

  sfr_in_if  in_if ();
  sfr_out_if out_if ();
  sfr_cfg_if cfg_if ();

  stream_find_and_replace DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if),
    .out_chan (out_if),
    .cfg_chan (cfg_if)
  );

  sfr_result_checker result_chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_mon     (in_if),
    .out_mon    (out_if),
    .cfg_mon    (cfg_if),
    .fail_count (fail_count),
    .awaited    (awaited)
  );

  // 8 ns clock
  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // Result side: random back-pressure, plus a long hold-off on request
  initial begin : receiver
    int unsigned hold_left;
    bit          hold_seen;
    hold_left = 0;
    hold_seen = 1'b0;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_token != hold_seen) begin
        hold_seen = hold_token;
        hold_left = LONG_HOLD;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // End the run if it hangs
  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("stream_find_and_replace_tb failed");
    $finish;
  end

  // Offer one input transaction, idling first at random; leave valid high
  task automatic send_item(input byte_t d, input logic p, input logic e);
    while ($urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid          <= 1'b1;
    in_if.data_byte      <= d;
    in_if.byte_present   <= p;
    in_if.end_of_content <= e;
    do @(posedge clk); while (in_if.ready !== 1'b1);
    if (p || e) phase_items++;
  endtask

  task automatic write_reg(input cfg_idx_t idx, input word_t val);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= val;
    do @(posedge clk); while (cfg_if.ready !== 1'b1);
  endtask

  // Write every register, then one unused index that must be ignored
  task automatic set_config(input word_t pat, input cnt_t plen, input word_t rep,
                            input cnt_t rlen);
    word_t junk;
    junk = {$urandom, $urandom};
    write_reg(CFG_PATTERN_BYTES, pat);
    write_reg(CFG_PATTERN_LENGTH, {junk[63:4], plen});
    write_reg(CFG_REPLACEMENT_BYTES, rep);
    write_reg(CFG_REPLACEMENT_LENGTH, {junk[59:0], rlen});
    write_reg(FIRST_UNUSED_INDEX + cfg_idx_t'($urandom_range(11)), {$urandom, $urandom});
    cfg_if.valid <= 1'b0;
    cur_pattern = pat;
    if (plen == 4'd0) cur_plen = 1;
    else if (plen > 4'(MAX_PATTERN)) cur_plen = MAX_PATTERN;
    else cur_plen = int'(plen);
  endtask

  // Stop offering, wait for every due result, then let the block go quiet
  task automatic drain();
    in_if.valid <= 1'b0;
    do @(posedge clk); while (awaited != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Pattern bytes from a small alphabet so that partial matches overlap
  function automatic word_t make_pattern();
    word_t w;
    int    r;
    for (int i = 0; i < 8; i++) begin
      r = $urandom_range(9);
      if (r < 4) w[i*8 +: 8] = CHAR_A;
      else if (r < 7) w[i*8 +: 8] = CHAR_B;
      else w[i*8 +: 8] = byte_t'($urandom);
    end
    return w;
  endfunction

  // One content: whole patterns, broken prefixes and stray bytes, with noise
  task automatic send_content();
    byte_t content[$];
    int    chunks;
    int    pick;
    int    cut;
    bit    finish;
    bit    end_on_byte;
    chunks      = $urandom_range(8);
    finish      = ($urandom_range(99) < 85);
    end_on_byte = ($urandom_range(1) == 1);
    for (int k = 0; k < chunks; k++) begin
      pick = $urandom_range(99);
      if (pick < 40) begin
        for (int j = 0; j < cur_plen; j++) content.push_back(cur_pattern[j*8 +: 8]);
      end else if (pick < 65) begin
        cut = $urandom_range(cur_plen);
        for (int j = 0; j < cut; j++) content.push_back(cur_pattern[j*8 +: 8]);
      end else if (pick < 75) begin
        content.push_back(($urandom_range(1) == 1) ? 8'hFF : 8'h00);
      end else begin
        content.push_back(byte_t'($urandom));
      end
    end
    foreach (content[j]) begin
      if ($urandom_range(19) == 0) send_item(byte_t'($urandom), 1'b0, 1'b0);
      send_item(content[j], 1'b1, finish && end_on_byte && (j == content.size() - 1));
    end
    if (finish && (!end_on_byte || content.size() == 0))
      send_item(byte_t'($urandom), 1'b0, 1'b1);
  endtask

  initial begin : stimulus
    word_t pat;
    word_t rep;
    cnt_t  plen;
    cnt_t  rlen;
    // hold every input at a known value through reset
    rst_n                <= 1'b0;
    in_if.valid          <= 1'b0;
    in_if.data_byte      <= 8'h00;
    in_if.byte_present   <= 1'b0;
    in_if.end_of_content <= 1'b0;
    cfg_if.valid         <= 1'b0;
    cfg_if.index         <= CFG_PATTERN_BYTES;
    cfg_if.data          <= '0;
    recv_idle_pct        <= 78;
    hold_token           <= 1'b0;
    send_idle_pct = 21;
    phase_items   = 0;
    cur_pattern   = '0;
    cur_plen      = 1;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset setting deletes zero bytes; bare ends with nothing left give empty markers
    send_item(8'h00, 1'b1, 1'b0);
    send_item(8'hFF, 1'b1, 1'b0);
    send_item(8'h5A, 1'b0, 1'b0);
    send_item(8'h00, 1'b0, 1'b1);
    send_item(8'hA5, 1'b0, 1'b1);
    drain();

    // Realign on an overlapping prefix, then leave a match pending
    set_config({40'd0, CHAR_B, CHAR_A, CHAR_A}, 4'd3, {$urandom, $urandom}, 4'd3);
    send_item(CHAR_A, 1'b1, 1'b0);
    send_item(CHAR_A, 1'b1, 1'b0);
    send_item(CHAR_A, 1'b1, 1'b0);
    send_item(CHAR_B, 1'b1, 1'b0);
    send_item(CHAR_A, 1'b1, 1'b0);
    send_item(CHAR_A, 1'b1, 1'b0);
    drain();

    // Change the pattern mid-match: the pending bytes finish against the old one
    set_config({48'd0, CHAR_C, CHAR_A}, 4'd2, {$urandom, $urandom}, 4'd8);
    send_item(CHAR_B, 1'b1, 1'b0);
    send_item(CHAR_A, 1'b1, 1'b0);
    send_item(CHAR_C, 1'b1, 1'b1);
    send_item(CHAR_A, 1'b1, 1'b1);
    drain();

    // Random phases, each with its own setting and one of three idle mixes
    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      if (phase < 4) begin
        send_idle_pct = 21;
        recv_idle_pct <= 78;
      end else if (phase < 8) begin
        send_idle_pct = 78;
        recv_idle_pct <= 21;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct <= 0;
      end
      pat  = make_pattern();
      rep  = {$urandom, $urandom};
      plen = cnt_t'($urandom_range(15));
      rlen = cnt_t'($urandom_range(15));
      case (phase)
        0: begin
          pat  = '0;
          plen = 4'd1;
          rlen = 4'd0;
        end
        1: begin
          pat  = '1;
          rep  = '1;
          plen = 4'd8;
          rlen = 4'd8;
        end
        2: begin
          plen = 4'd0;
          rlen = 4'd15;
        end
        3: begin
          rep  = '0;
          plen = 4'd15;
          rlen = 4'd1;
        end
        default: ;
      endcase
      set_config(pat, plen, rep, rlen);
      // stall the result side while content keeps coming, to fill the block
      if (phase == HOLD_PHASE) hold_token <= ~hold_token;
      phase_items = 0;
      while (phase_items < ITEMS_PER_PHASE) send_content();
      drain();
    end

    if (fail_count == 0 && awaited == 0) begin
      $display("stream_find_and_replace_tb passed");
    end else begin
      $display("stream_find_and_replace_tb failed");
    end
    $finish;
  end

endmodule
